### rtl/i2crm_pkg.sv
// Shared types, constants and helper functions for the I2C register map target.
package i2crm_pkg;

    localparam int MAP_DEPTH_DEF = 256;
    localparam int PTR_W         = 8;
    localparam int SIZE_W        = 9;
    localparam int DATA_W        = 8;
    localparam int OP_W          = 3;

    typedef enum logic [OP_W-1:0] {
        OP_WR_ADDR = 3'd0,
        OP_RD_ADDR = 3'd1,
        OP_RX_BYTE = 3'd2,
        OP_TX_RDY  = 3'd3,
        OP_NACK    = 3'd4,
        OP_STOP    = 3'd5
    } t_op;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             tx;
        logic             hit;
        logic [PTR_W-1:0] idx;
        logic [PTR_W-1:0] ptr;
    } t_access;

    function automatic logic [PTR_W-1:0] f_advance(input logic [PTR_W-1:0] p,
                                                   input logic [SIZE_W-1:0] eff);
        logic [SIZE_W-1:0] n;
        n = {1'b0, p} + SIZE_W'(1);
        return (n >= eff) ? '0 : n[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] f_step_back(input logic [PTR_W-1:0] p,
                                                     input logic [SIZE_W-1:0] eff);
        logic [SIZE_W-1:0] m;
        m = eff - SIZE_W'(1);
        return (p == '0) ? m[PTR_W-1:0] : p - PTR_W'(1);
    endfunction

endpackage

### rtl/i2crm_store.sv
// Register map byte store with per-entry valid bits and registered read.
module i2crm_store import i2crm_pkg::*; #(
    parameter int MAP_DEPTH = MAP_DEPTH_DEF,
    parameter int ADDR_W    = $clog2(MAP_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data,
    output logic              o_rd_vld
);

    logic [DATA_W-1:0] r_mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_vld;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

endmodule

### rtl/i2crm_index.sv
// Pointer, start index and map size state; decodes one bus event into a store access.
module i2crm_index import i2crm_pkg::*; #(
    parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [DATA_W-1:0] i_rx_byte,
    input  logic              i_cfg_wr,
    input  logic [SIZE_W-1:0] i_cfg_map_size,
    output t_access           o_access
);

    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [PTR_W-1:0]  r_start, n_start;
    logic              r_expect, n_expect;
    logic [SIZE_W-1:0] r_eff, n_eff;
    t_access           w_acc;

    always_comb begin
        if (i_cfg_map_size == '0) begin
            n_eff = SIZE_W'(1);
        end else if (i_cfg_map_size > SIZE_W'(MAP_DEPTH)) begin
            n_eff = SIZE_W'(MAP_DEPTH);
        end else begin
            n_eff = i_cfg_map_size;
        end
    end

    always_comb begin
        n_ptr     = r_ptr;
        n_start   = r_start;
        n_expect  = r_expect;
        w_acc     = '0;
        w_acc.idx = r_ptr;
        case (i_operation)
            OP_WR_ADDR: begin
                n_expect = 1'b1;
            end
            OP_RD_ADDR: begin
                w_acc.idx   = r_start;
                w_acc.rd_en = 1'b1;
                w_acc.tx    = 1'b1;
                n_ptr       = f_advance(r_start, r_eff);
            end
            OP_RX_BYTE: begin
                if (r_expect) begin
                    n_expect = 1'b0;
                    n_start  = i_rx_byte;
                    n_ptr    = i_rx_byte;
                end else begin
                    w_acc.wr_en = ({1'b0, r_ptr} < r_eff);
                    n_ptr       = f_advance(r_ptr, r_eff);
                end
            end
            OP_TX_RDY: begin
                w_acc.rd_en = 1'b1;
                w_acc.tx    = 1'b1;
                n_ptr       = f_advance(r_ptr, r_eff);
            end
            OP_NACK: begin
                n_ptr = f_step_back(r_ptr, r_eff);
            end
            default: begin
            end
        endcase
        w_acc.hit = ({1'b0, w_acc.idx} < r_eff);
        w_acc.ptr = n_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_start  <= '0;
            r_expect <= 1'b0;
            r_eff    <= SIZE_W'(MAP_DEPTH);
        end else begin
            if (i_accept) begin
                r_ptr    <= n_ptr;
                r_start  <= n_start;
                r_expect <= n_expect;
            end
            if (i_cfg_wr) begin
                r_eff <= n_eff;
            end
        end
    end

    always_comb begin
        o_access       = w_acc;
        o_access.wr_en = w_acc.wr_en & i_accept;
        o_access.rd_en = w_acc.rd_en & w_acc.hit & i_accept;
    end

endmodule

### rtl/i2c_register_map_target_top.sv
// Top level of the I2C register map target: event decode, store and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one bus event word:
//   i_operation and i_rx_byte. Output channel (o_out_valid / i_out_ready)
//   returns exactly one result word per event: o_tx_valid, o_tx_byte and
//   o_current_index (the pointer after the event).
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the map size;
//   it is always ready and is meant to be written while the block is idle.
//   Pipeline: a result passes through the registered store read and then
//   the result register before it leaves on the output channel.
//   Throughput: one event per cycle while o_in_ready is high; the pointer
//   update and the store access, if any, of each event complete in the accept cycle.
//   Reset: pointer, start index and the index-expected flag clear, the map
//   size returns to the full depth, and every store entry reads as zero via
//   per-entry valid bits that reset clears at once; no clearing pass.
//   Stall: when i_out_ready is low the result register holds and one more
//   event is kept in the read stage; o_in_ready drops only when both are full.
module i2c_register_map_target_top import i2crm_pkg::*; #(
    parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [DATA_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_tx_valid,
    output logic [DATA_W-1:0] o_tx_byte,
    output logic [PTR_W-1:0]  o_current_index,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_map_size
);

    localparam int ADDR_W = $clog2(MAP_DEPTH);

    t_access           w_acc;
    logic              w_in_acc;
    logic              w_advance;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_rd_vld;

    logic              r_s1_valid;
    logic              r_s1_tx;
    logic              r_s1_hit;
    logic [PTR_W-1:0]  r_s1_ptr;

    logic              r_out_valid;
    logic              r_out_tx_valid;
    logic [DATA_W-1:0] r_out_tx_byte, n_out_tx_byte;
    logic [PTR_W-1:0]  r_out_index;

    assign o_cfg_ready = 1'b1;
    assign w_advance   = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || w_advance;
    assign w_in_acc    = i_in_valid && o_in_ready;

    i2crm_index #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_index (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_in_acc),
        .i_operation    (i_operation),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_map_size (i_cfg_map_size),
        .o_access       (w_acc)
    );

    i2crm_store #(
        .MAP_DEPTH (MAP_DEPTH),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_acc.wr_en),
        .i_rd_en   (w_acc.rd_en),
        .i_addr    (w_acc.idx[ADDR_W-1:0]),
        .i_wr_data (i_rx_byte),
        .o_rd_data (w_rd_data),
        .o_rd_vld  (w_rd_vld)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_tx  <= w_acc.tx;
            r_s1_hit <= w_acc.hit;
            r_s1_ptr <= w_acc.ptr;
        end
        if (r_s1_valid && w_advance) begin
            r_out_tx_valid <= r_s1_tx;
            r_out_tx_byte  <= n_out_tx_byte;
            r_out_index    <= r_s1_ptr;
        end
    end

    always_comb begin
        n_out_tx_byte = (r_s1_tx && r_s1_hit && w_rd_vld) ? w_rd_data : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (r_s1_valid && w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_valid      = r_out_tx_valid;
    assign o_tx_byte       = r_out_tx_byte;
    assign o_current_index = r_out_index;

`ifndef SYNTHESIS
    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_valid |-> o_tx_byte == '0)
        else $error("tx byte nonzero without tx valid");

    a_ready_low_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid && !i_out_ready)
        else $error("input stalled while pipeline has room");

    a_read_event_sets_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_operation == OP_RD_ADDR || i_operation == OP_TX_RDY)
        |=> r_s1_valid && r_s1_tx)
        else $error("read event lost its tx flag");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_s1_valid)
        else $error("pipeline valid after reset");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the I2C register map target against a pointer/store predictor.
module tb_top;
    import i2crm_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam logic [SIZE_W-1:0] SIZE_PLAN [10] = '{
        9'd256, 9'd1, 9'd2, 9'd7, 9'd300, 9'd511, 9'd100, 9'd255, 9'd17, 9'd256
    };

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] rx;
    } t_bus_event;

    typedef struct {
        logic              tx_valid;
        logic [DATA_W-1:0] tx_byte;
        logic [PTR_W-1:0]  index;
    } t_reply;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_operation    = '0;
    logic [DATA_W-1:0] i_rx_byte      = '0;
    logic              o_out_valid;
    logic              i_out_ready    = 1'b0;
    logic              o_tx_valid;
    logic [DATA_W-1:0] o_tx_byte;
    logic [PTR_W-1:0]  o_current_index;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_map_size = '0;

    t_bus_event event_q [$];
    t_reply     replies_due [$];

    logic [DATA_W-1:0] map_bytes [MAP_DEPTH_DEF] = '{default: 8'h00};
    logic [PTR_W-1:0]  map_start       = '0;
    logic [PTR_W-1:0]  map_ptr         = '0;
    logic              index_pending   = 1'b0;
    logic [SIZE_W-1:0] map_size_shadow = 9'd256;

    int  fault_count    = 0;
    int  replies_seen   = 0;
    int  send_gap_pct   = 14;
    int  recv_gap_pct   = 14;
    int  hold_left      = 0;
    bit  long_hold_done = 1'b0;

    i2c_register_map_target_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_tx_valid      (o_tx_valid),
        .o_tx_byte       (o_tx_byte),
        .o_current_index (o_current_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_map_size  (i_cfg_map_size)
    );

    function automatic int live_size();
        int s;
        s = int'(map_size_shadow);
        if (s < 1) s = 1;
        if (s > MAP_DEPTH_DEF) s = MAP_DEPTH_DEF;
        return s;
    endfunction

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p, input int lim);
        return (int'(p) + 1 >= lim) ? 8'h00 : p + 8'd1;
    endfunction

    function automatic t_reply apply_bus_event(input t_bus_event ev);
        t_reply r;
        int     lim;
        lim = live_size();
        r.tx_valid = 1'b0;
        r.tx_byte  = 8'h00;
        case (ev.op)
            OP_WR_ADDR: index_pending = 1'b1;
            OP_RD_ADDR, OP_TX_RDY: begin
                if (ev.op == OP_RD_ADDR) map_ptr = map_start;
                r.tx_valid = 1'b1;
                r.tx_byte  = (int'(map_ptr) < lim) ? map_bytes[map_ptr] : 8'h00;
                map_ptr    = next_ptr(map_ptr, lim);
            end
            OP_RX_BYTE: begin
                if (index_pending) begin
                    index_pending = 1'b0;
                    map_start     = ev.rx;
                    map_ptr       = ev.rx;
                end else begin
                    if (int'(map_ptr) < lim) map_bytes[map_ptr] = ev.rx;
                    map_ptr = next_ptr(map_ptr, lim);
                end
            end
            OP_NACK: map_ptr = (map_ptr == 8'h00) ? 8'(lim - 1) : map_ptr - 8'd1;
            default: ;
        endcase
        r.index = map_ptr;
        return r;
    endfunction

    task automatic queue_event(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] rx);
        event_q.push_back('{op: op, rx: rx});
    endtask

    task automatic queue_random_traffic(input int count);
        int               lim;
        int               base;
        int               kind;
        int               n;
        logic [PTR_W-1:0] idx;
        lim  = live_size();
        base = event_q.size();
        while (event_q.size() - base < count) begin
            kind = $urandom_range(0, 9);
            n    = $urandom_range(0, 6);
            idx  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, lim - 1));
            if (kind <= 3) begin
                queue_event(OP_WR_ADDR, 8'($urandom_range(0, 255)));
                queue_event(OP_RX_BYTE, idx);
                repeat (n) queue_event(OP_RX_BYTE, 8'($urandom_range(0, 255)));
                queue_event(OP_STOP, 8'($urandom_range(0, 255)));
            end else if (kind <= 7) begin
                if (kind <= 6) begin
                    queue_event(OP_WR_ADDR, 8'($urandom_range(0, 255)));
                    queue_event(OP_RX_BYTE, idx);
                end
                queue_event(OP_RD_ADDR, 8'($urandom_range(0, 255)));
                repeat (n) queue_event(OP_TX_RDY, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) queue_event(OP_NACK, 8'($urandom_range(0, 255)));
                queue_event(OP_STOP, 8'($urandom_range(0, 255)));
            end else begin
                repeat (n + 1) queue_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_idle();
        while (event_q.size() != 0 || i_in_valid || replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_map_size(input logic [SIZE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_map_size <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        map_size_shadow = value;
        i_cfg_valid    <= 1'b0;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                replies_due.push_back(apply_bus_event('{op: i_operation, rx: i_rx_byte}));
            if (!i_in_valid || o_in_ready) begin
                if (event_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    i_in_valid  <= 1'b1;
                    i_operation <= event_q[0].op;
                    i_rx_byte   <= event_q[0].rx;
                    void'(event_q.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected reply tx_valid=%0d tx_byte=%h index=%0d",
                             $time, o_tx_valid, o_tx_byte, o_current_index);
                    fault_count++;
                end else begin
                    if (o_tx_valid !== replies_due[0].tx_valid) begin
                        $display("%0t: tx_valid expected %0d, got %0d",
                                 $time, replies_due[0].tx_valid, o_tx_valid);
                        fault_count++;
                    end
                    if (o_tx_byte !== replies_due[0].tx_byte) begin
                        $display("%0t: tx_byte expected %h, got %h",
                                 $time, replies_due[0].tx_byte, o_tx_byte);
                        fault_count++;
                    end
                    if (o_current_index !== replies_due[0].index) begin
                        $display("%0t: current_index expected %0d, got %0d",
                                 $time, replies_due[0].index, o_current_index);
                        fault_count++;
                    end
                    void'(replies_due.pop_front());
                end
                replies_seen++;
            end
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (!long_hold_done && replies_seen > 200 && event_q.size() > 20) begin
                long_hold_done <= 1'b1;
                hold_left      <= LONG_HOLD_CYCLES;
                i_out_ready    <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : run_phases
        int k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_event(OP_RD_ADDR, 8'h00);
        queue_event(OP_TX_RDY,  8'hFF);
        queue_event(OP_NACK,    8'h00);
        queue_event(OP_NACK,    8'h00);
        queue_event(OP_NACK,    8'h00);
        queue_event(OP_WR_ADDR, 8'h00);
        queue_event(OP_STOP,    8'h00);
        queue_event(OP_WR_ADDR, 8'h00);
        queue_event(OP_RX_BYTE, 8'hFF);
        queue_event(OP_RX_BYTE, 8'hA5);
        queue_event(OP_RX_BYTE, 8'h00);
        queue_event(OP_RD_ADDR, 8'h00);
        queue_event(OP_TX_RDY,  8'h00);
        queue_event(OP_SPARE_6, 8'h5A);
        queue_event(OP_SPARE_7, 8'hFF);
        wait_idle();

        write_map_size(9'd3);
        queue_event(OP_WR_ADDR, 8'h00);
        queue_event(OP_RX_BYTE, 8'hC8);
        queue_event(OP_RX_BYTE, 8'h3C);
        queue_event(OP_RD_ADDR, 8'h00);
        queue_event(OP_NACK,    8'h00);
        queue_event(OP_TX_RDY,  8'h00);
        queue_event(OP_RX_BYTE, 8'h81);
        queue_event(OP_STOP,    8'h00);
        wait_idle();

        write_map_size(9'd0);
        queue_event(OP_TX_RDY, 8'h00);
        queue_event(OP_NACK,   8'h00);
        wait_idle();

        for (k = 0; k < 10; k++) begin
            write_map_size(SIZE_PLAN[k]);
            send_gap_pct = (k == 3) ? 0 : 14;
            recv_gap_pct = (k == 3) ? 0 : 14;
            queue_random_traffic(70);
            wait_idle();
        end

        repeat (6) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
rtl/i2crm_pkg.sv
rtl/i2crm_store.sv
rtl/i2crm_index.sv
rtl/i2c_register_map_target_top.sv
tb/tb_top.sv
